/* hw/rtl/lpd_pkg.sv */
package lpd_pkg;

   // shared divider datapath
   localparam int DivW     = 34;
   localparam int DivisorW = 10;
   localparam int CntW     = 5;
   localparam int MulAW    = 17;
   localparam int MulBW    = 16;
   localparam int MulPW    = MulAW + MulBW;

   // quotient digit pairs per division pass (numerator bits / 2, rounded up)
   localparam int Div1Iters = 14;   // torque*friction, 28 bits
   localparam int Div2Iters = 17;   // scaled demand, 33 bits
   localparam int Div3Iters = 11;   // filter numerator, 21 bits

   localparam int Div1Shift = DivW - 2 * Div1Iters;
   localparam int Div2Shift = DivW - 2 * Div2Iters;
   localparam int Div3Shift = DivW - 2 * Div3Iters;

   localparam logic [DivisorW-1:0] ClutchDivisor = 10'd100;
   localparam logic [DivisorW-1:0] ScaleDivisor  = 10'd1000;
   localparam logic [MulBW-1:0]    ScaleFactor   = 16'd1000;
   localparam logic [8:0]          TempOffset    = 9'd50;
   localparam logic [7:0]          WeightSat     = 8'hFF;
   localparam logic [7:0]          WeightCap     = 8'hFE;

   typedef logic [2:0]  gear_idx_type;
   typedef logic [12:0] pressure_type;

   typedef enum logic [2:0] {
      RegMultFirst  = 3'd0,
      RegMultOther  = 3'd1,
      RegRegSpring  = 3'd2,
      RegMinPress   = 3'd3,
      RegSmoothW    = 3'd4,
      RegFlushTemp  = 3'd5,
      RegRestDur    = 3'd6,
      RegFlushDur   = 3'd7
   } reg_index_type;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_MULR  = 14'b00000000000010,
      S_MUL1  = 14'b00000000000100,
      S_DIV1  = 14'b00000000001000,
      S_MUL2  = 14'b00000000010000,
      S_SUB   = 14'b00000000100000,
      S_DIV2  = 14'b00000001000000,
      S_CLMP  = 14'b00000010000000,
      S_FLUSH = 14'b00000100000000,
      S_MUL3  = 14'b00001000000000,
      S_LD3   = 14'b00010000000000,
      S_DIV3  = 14'b00100000000000,
      S_QUO   = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   function automatic gear_idx_type gear_index(input logic [7:0] code);
      gear_idx_type idx;
      if (code >= 8'd1 && code <= 8'd5) idx = code[2:0];
      else if (code == 8'd10) idx = 3'd6;
      else idx = 3'd0;
      return idx;
   endfunction

   // strongest holding clutch friction by gear index
   function automatic logic [11:0] gear_friction(input gear_idx_type idx);
      logic [11:0] f;
      case (idx)
         3'd1: f = 12'd3076;
         3'd2: f = 12'd1871;
         3'd3: f = 12'd1101;
         3'd4: f = 12'd1673;
         3'd5: f = 12'd1390;
         3'd6: f = 12'd3076;
         default: f = 12'd0;
      endcase
      return f;
   endfunction

   // release spring pressure of that clutch
   function automatic logic [10:0] gear_release(input gear_idx_type idx);
      logic [10:0] r;
      case (idx)
         3'd1, 3'd2, 3'd6: r = 11'd1205;
         3'd3, 3'd4, 3'd5: r = 11'd846;
         default: r = 11'd0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/line_pressure_demand_with_flush.sv */
// Line pressure demand with flush. Each accepted req word (gear code, input
// torque, oil temperature, flush enable) yields one rsp word with the
// demanded modulating line pressure in millibar and the flush flag. The
// demand is clutch torque pressure plus release spring, scaled per gear,
// less the regulator spring, clamped to MAX_PRESSURE, floored at the minimum
// pressure unless a flush is running, and smoothed on the way down. One
// shared multiplier and one shared 2-bit-per-cycle restoring divider do all
// arithmetic under a small sequencer; req_stall is high while a word is in
// work. A forward or reverse word that gets smoothed runs three divider
// passes between its multiply, load and flush steps; park, neutral and
// unknown gears skip the first two passes, and a word that is not smoothed
// skips the third. The rsp word sits in an output register, so the next
// req word is accepted while it waits; only a finish against a still-stalled
// rsp word holds the sequencer. Config writes via csr_* are always ready and
// must only be made while the block is idle.
module line_pressure_demand_with_flush #(
   parameter int MAX_PRESSURE = 7700
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_gear_code,
   input  logic [15:0]            req_input_torque,
   input  logic [7:0]             req_oil_temperature,
   input  logic                   req_flush_enable,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [12:0]            rsp_line_pressure,
   output logic                   rsp_flushing,
   // config write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  lpd_pkg::reg_index_type csr_index,
   input  logic [15:0]            csr_data
);
   import lpd_pkg::*;

   localparam pressure_type MaxPressure = 13'(MAX_PRESSURE);

   // config registers
   logic [15:0] mult_first_ff, mult_other_ff, reg_spring_ff, min_press_ff;
   logic [7:0]  smooth_w_ff, flush_temp_ff;
   logic [15:0] rest_dur_ff, flush_dur_ff;

   // persistent state
   pressure_type last_ff, last_in;
   logic         active_ff, active_in;
   logic [15:0]  cd_ff, cd_in;

   // sequencer and latched request word
   state_type    state_ff, state_in;
   gear_idx_type gid_ff, gid_in;
   logic [15:0]  torque_ff, torque_in;
   logic [7:0]   temp_ff, temp_in;
   logic         enable_ff, enable_in;

   // datapath registers
   logic [25:0]         reg_ff, reg_in;       // regulator_spring * 1000
   logic [MulPW-1:0]    prod_ff, prod_in;
   pressure_type        res_ff, res_in;
   logic [DivW-1:0]     num_ff, num_in;       // numerator, quotient shifts in
   logic [DivisorW-1:0] rem_ff, rem_in;
   logic [DivisorW-1:0] div_ff, div_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   pressure_type rsp_lp_ff, rsp_lp_in;
   logic         rsp_fl_ff, rsp_fl_in;

   // shared multiplier
   logic [MulAW-1:0] mul_a;
   logic [MulBW-1:0] mul_b;
   logic [MulPW-1:0] mul_p;

   // shared divider step
   logic [DivW-1:0]     step_num;
   logic [DivisorW-1:0] step_rem;

   logic        req_take, rsp_take, out_free;
   logic [7:0]  weight;
   logic [15:0] clutch_p;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_pressure = rsp_lp_ff;
   assign rsp_flushing      = rsp_fl_ff;

   // weight 255 behaves as 254
   assign weight   = (smooth_w_ff == WeightSat) ? WeightCap : smooth_w_ff;
   assign clutch_p = num_ff[15:0];

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MULR: begin
            mul_a = MulAW'(reg_spring_ff);
            mul_b = ScaleFactor;
         end
         S_MUL1: begin
            mul_a = MulAW'(torque_ff);
            mul_b = MulBW'(gear_friction(gid_ff));
         end
         S_MUL2: begin
            mul_a = MulAW'(clutch_p) + MulAW'(gear_release(gid_ff));
            mul_b = ((gid_ff == 3'd1) || (gid_ff == 3'd6)) ? mult_first_ff
                                                           : mult_other_ff;
         end
         S_MUL3: begin
            mul_a = MulAW'(last_ff);
            mul_b = MulBW'(weight);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // two restoring quotient bits per cycle
   always_comb begin
      logic [DivisorW:0] t;
      step_num = num_ff;
      step_rem = rem_ff;
      for (int i = 0; i < 2; i++) begin
         t        = {step_rem, step_num[DivW-1]};
         step_num = {step_num[DivW-2:0], 1'b0};
         if (t >= {1'b0, div_ff}) begin
            step_rem    = DivisorW'(t - {1'b0, div_ff});
            step_num[0] = 1'b1;
         end else begin
            step_rem = t[DivisorW-1:0];
         end
      end
   end

   // sequencer
   always_comb begin
      logic        flush_ok;
      logic [15:0] floored;
      pressure_type r;

      state_in     = state_ff;
      gid_in       = gid_ff;
      torque_in    = torque_ff;
      temp_in      = temp_ff;
      enable_in    = enable_ff;
      reg_in       = reg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      active_in    = active_ff;
      cd_in        = cd_ff;
      rsp_lp_in    = rsp_lp_ff;
      rsp_fl_in    = rsp_fl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      flush_ok     = 1'b0;
      floored      = '0;
      r            = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               gid_in    = gear_index(req_gear_code);
               torque_in = req_input_torque;
               temp_in   = req_oil_temperature;
               enable_in = req_flush_enable;
               // flush timer ticks once per enabled word, holds at zero
               if (req_flush_enable && (cd_ff != 16'd0)) cd_in = cd_ff - 16'd1;
               state_in  = S_MULR;
            end
         end
         S_MULR: begin
            reg_in = 26'(mul_p);
            if (gid_ff == 3'd0) begin
               res_in   = '0;
               state_in = S_FLUSH;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            num_in   = DivW'(mul_p) << Div1Shift;
            rem_in   = '0;
            div_in   = ClutchDivisor;
            cnt_in   = CntW'(Div1Iters - 1);
            state_in = S_DIV1;
         end
         S_DIV1: begin
            num_in = step_num;
            rem_in = step_rem;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = mul_p;
            state_in = S_SUB;
         end
         S_SUB: begin
            if (prod_ff >= MulPW'(reg_ff)) begin
               num_in   = DivW'(prod_ff - MulPW'(reg_ff)) << Div2Shift;
               rem_in   = '0;
               div_in   = ScaleDivisor;
               cnt_in   = CntW'(Div2Iters - 1);
               state_in = S_DIV2;
            end else begin
               res_in   = '0;
               state_in = S_FLUSH;
            end
         end
         S_DIV2: begin
            num_in = step_num;
            rem_in = step_rem;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) state_in = S_CLMP;
         end
         S_CLMP: begin
            res_in   = (num_ff > DivW'(MaxPressure)) ? MaxPressure : num_ff[12:0];
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            flush_ok = enable_ff && (16'(last_ff) < min_press_ff) && (res_ff == '0)
                       && (({1'b0, temp_ff} + TempOffset) >= {1'b0, flush_temp_ff})
                       && (rest_dur_ff != 16'd0);
            if (flush_ok) begin
               if (!active_ff) begin
                  if (cd_ff == 16'd0) begin
                     active_in = 1'b1;
                     cd_in     = flush_dur_ff;
                  end
               end else if (cd_ff == 16'd0) begin
                  active_in = 1'b0;
                  cd_in     = rest_dur_ff;
               end
            end else begin
               active_in = 1'b0;
               cd_in     = 16'd0;
            end
            r = res_ff;
            // minimum floor only outside a flush
            if (!active_in) begin
               floored = (16'(res_ff) < min_press_ff) ? min_press_ff : 16'(res_ff);
               r = (floored > 16'(MaxPressure)) ? MaxPressure : floored[12:0];
            end
            res_in   = r;
            state_in = (r < last_ff) ? S_MUL3 : S_DONE;
         end
         S_MUL3: begin
            prod_in  = mul_p;
            state_in = S_LD3;
         end
         S_LD3: begin
            num_in   = DivW'(prod_ff[20:0] + 21'(res_ff)) << Div3Shift;
            rem_in   = '0;
            div_in   = DivisorW'(weight) + DivisorW'(1);
            cnt_in   = CntW'(Div3Iters - 1);
            state_in = S_DIV3;
         end
         S_DIV3: begin
            num_in = step_num;
            rem_in = step_rem;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) state_in = S_QUO;
         end
         S_QUO: begin
            res_in   = num_ff[12:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_lp_in    = res_ff;
               rsp_fl_in    = active_ff;
               rsp_valid_in = 1'b1;
               last_in      = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= MaxPressure;
         active_ff    <= 1'b0;
         cd_ff        <= 16'd0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         active_ff    <= active_in;
         cd_ff        <= cd_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload and datapath
   always_ff @(posedge clock) begin
      gid_ff    <= gid_in;
      torque_ff <= torque_in;
      temp_ff   <= temp_in;
      enable_ff <= enable_in;
      reg_ff    <= reg_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      rsp_lp_ff <= rsp_lp_in;
      rsp_fl_ff <= rsp_fl_in;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_first_ff <= 16'd431;
         mult_other_ff <= 16'd592;
         reg_spring_ff <= 16'd1828;
         min_press_ff  <= 16'd500;
         smooth_w_ff   <= 8'd15;
         flush_temp_ff <= 8'd75;
         rest_dur_ff   <= 16'd30000;
         flush_dur_ff  <= 16'd50;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            RegMultFirst: mult_first_ff <= csr_data;
            RegMultOther: mult_other_ff <= csr_data;
            RegRegSpring: reg_spring_ff <= csr_data;
            RegMinPress:  min_press_ff  <= csr_data;
            RegSmoothW:   smooth_w_ff   <= csr_data[7:0];
            RegFlushTemp: flush_temp_ff <= csr_data[7:0];
            RegRestDur:   rest_dur_ff   <= csr_data;
            RegFlushDur:  flush_dur_ff  <= csr_data;
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // delivered pressure never exceeds the clamp
   a_rsp_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_pressure <= MaxPressure))
      else $error("line pressure above maximum");

   // smoothed value lies between new demand and last pressure
   a_filter_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QUO) |-> ((num_ff >= DivW'(res_ff)) && (num_ff <= DivW'(last_ff))))
      else $error("filter output out of range");

   // flush flag only moves in the flush step
   a_active_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && (state_ff != S_FLUSH)) |=> $stable(active_ff))
      else $error("flush flag changed outside flush step");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
   import lpd_pkg::*;

   localparam int MaxPressure = 7700;
   // cycles without any accepted word before the run is declared hung
   localparam int IdleLimit   = 2000;

   // gear selector codes
   localparam logic [7:0] GearFirst    = 8'd1;
   localparam logic [7:0] GearSecond   = 8'd2;
   localparam logic [7:0] GearThird    = 8'd3;
   localparam logic [7:0] GearFourth   = 8'd4;
   localparam logic [7:0] GearFifth    = 8'd5;
   localparam logic [7:0] GearPark     = 8'd8;
   localparam logic [7:0] GearNeutral  = 8'd9;
   localparam logic [7:0] GearRevFirst = 8'd10;

   typedef struct packed {
      logic [7:0]  gear_code;
      logic [15:0] torque;
      logic [7:0]  oil_temp;
      logic        flush_en;
   } demand_req_t;

   typedef struct packed {
      logic [12:0] pressure;
      logic        flushing;
   } demand_t;

   typedef struct packed {
      logic [15:0] mult_first;
      logic [15:0] mult_other;
      logic [15:0] reg_spring;
      logic [15:0] min_press;
      logic [7:0]  smooth_w;
      logic [7:0]  flush_temp;
      logic [15:0] rest_dur;
      logic [15:0] flush_dur;
   } calib_t;

   // one directed word; 'typed' marks rows whose result is written out by hand
   typedef struct packed {
      demand_req_t word;
      logic        typed;
      demand_t     want;
   } script_row_t;

   localparam calib_t DefaultCalib = '{
      mult_first: 16'd431, mult_other: 16'd592, reg_spring: 16'd1828,
      min_press: 16'd500, smooth_w: 8'd15, flush_temp: 8'd75,
      rest_dur: 16'd30000, flush_dur: 16'd50
   };

   // Directed words, all under the reset calibration. The first three results
   // follow by hand: park falls from 7700 toward the 500 floor with weight 15
   // ((500 + 15*7700)/16 = 7250), full torque in first saturates at 7700, and
   // neutral falls back to 7250 again.
   script_row_t directed_rows [0:19] = '{
      {GearPark,     16'd0,     8'd0,   1'b0, 1'b1, 13'd7250, 1'b0},
      {GearFirst,    16'hFFFF,  8'hFF,  1'b1, 1'b1, 13'd7700, 1'b0},
      {GearNeutral,  16'hFFFF,  8'hFF,  1'b1, 1'b1, 13'd7250, 1'b0},
      {8'd0,         16'd0,     8'd0,   1'b1, 1'b0, 13'd0,    1'b0},
      {8'hFF,        16'hFFFF,  8'hFF,  1'b0, 1'b0, 13'd0,    1'b0},
      {GearFirst,    16'd0,     8'd128, 1'b1, 1'b0, 13'd0,    1'b0},
      // clutch pressure just past 16 bits wraps to a tiny value
      {GearFirst,    16'd2131,  8'd90,  1'b1, 1'b0, 13'd0,    1'b0},
      {GearFirst,    16'd2130,  8'd90,  1'b0, 1'b0, 13'd0,    1'b0},
      {GearSecond,   16'hFFFF,  8'd20,  1'b1, 1'b0, 13'd0,    1'b0},
      {GearThird,    16'd30000, 8'd40,  1'b0, 1'b0, 13'd0,    1'b0},
      {GearFourth,   16'd1000,  8'd60,  1'b1, 1'b0, 13'd0,    1'b0},
      {GearFifth,    16'd40000, 8'd25,  1'b1, 1'b0, 13'd0,    1'b0},
      {GearRevFirst, 16'hFFFF,  8'd0,   1'b0, 1'b0, 13'd0,    1'b0},
      {GearRevFirst, 16'd0,     8'd200, 1'b1, 1'b0, 13'd0,    1'b0},
      {8'd6,         16'd5000,  8'd77,  1'b1, 1'b0, 13'd0,    1'b0},
      {8'd7,         16'd12345, 8'd100, 1'b0, 1'b0, 13'd0,    1'b0},
      {8'd11,        16'd777,   8'd180, 1'b1, 1'b0, 13'd0,    1'b0},
      {GearThird,    16'd1,     8'd1,   1'b1, 1'b0, 13'd0,    1'b0},
      {GearPark,     16'd0,     8'hFF,  1'b1, 1'b0, 13'd0,    1'b0},
      {GearFifth,    16'd700,   8'd55,  1'b0, 1'b0, 13'd0,    1'b0}
   };

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_gear_code       = '0;
   logic [15:0]            req_input_torque    = '0;
   logic [7:0]             req_oil_temperature = '0;
   logic                   req_flush_enable    = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall           = 1'b0;
   logic [12:0]            rsp_line_pressure;
   logic                   rsp_flushing;
   logic                   csr_valid           = 1'b0;
   logic                   csr_ready;
   reg_index_type          csr_index           = RegMultFirst;
   logic [15:0]            csr_data            = '0;

   // predictor state: calibration plus the block's own memory
   calib_t      calib;
   logic [12:0] held_pressure;
   logic        in_flush;
   logic [15:0] flush_timer;

   demand_t     pending_demand [$];
   int          mismatches = 0;
   int          rsp_count  = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   bit          calm_tx = 1'b0;
   bit          calm_rx = 1'b0;

   always #1 clock = ~clock;

   line_pressure_demand_with_flush #(
      .MAX_PRESSURE(MaxPressure)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_gear_code(req_gear_code),
      .req_input_torque(req_input_torque),
      .req_oil_temperature(req_oil_temperature),
      .req_flush_enable(req_flush_enable),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_pressure(rsp_line_pressure),
      .rsp_flushing(rsp_flushing),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Demand for one req word; advances the flush machine and the held
   // pressure exactly as one update of the block does.
   task automatic predict_demand(input demand_req_t w, output demand_t r);
      logic        driven;
      logic [11:0] fric;
      logic [10:0] spring;
      logic [15:0] mult;
      logic [27:0] clutch_raw;
      logic [15:0] clutch;
      logic [16:0] total;
      logic [32:0] scaled;
      logic [32:0] offset;
      logic [32:0] excess;
      logic [15:0] demand;
      logic [7:0]  wt;
      logic [21:0] blend;

      driven = 1'b1;
      fric   = '0;
      spring = '0;
      mult   = calib.mult_other;
      case (w.gear_code)
         GearFirst, GearRevFirst: begin
            fric   = 12'd3076;
            spring = 11'd1205;
            mult   = calib.mult_first;
         end
         GearSecond: begin
            fric   = 12'd1871;
            spring = 11'd1205;
         end
         GearThird: begin
            fric   = 12'd1101;
            spring = 11'd846;
         end
         GearFourth: begin
            fric   = 12'd1673;
            spring = 11'd846;
         end
         GearFifth: begin
            fric   = 12'd1390;
            spring = 11'd846;
         end
         default: driven = 1'b0;   // park, neutral, unknown: no demand
      endcase

      demand = '0;
      if (driven) begin
         clutch_raw = 28'(w.torque) * 28'(fric);
         clutch     = 16'(clutch_raw / 28'd100);   // kept to 16 bits
         total      = 17'(clutch) + 17'(spring);
         scaled     = 33'(total) * 33'(mult);
         offset     = 33'(calib.reg_spring) * 33'd1000;
         if (scaled >= offset) begin
            excess = (scaled - offset) / 33'd1000;
            demand = (excess > 33'(MaxPressure)) ? 16'(MaxPressure) : excess[15:0];
         end
      end

      // timer runs on enabled updates only and holds at zero
      if (w.flush_en && flush_timer != 16'd0) flush_timer = flush_timer - 16'd1;

      if (w.flush_en && 16'(held_pressure) < calib.min_press && demand == 16'd0 &&
          9'(w.oil_temp) + 9'd50 >= 9'(calib.flush_temp) && calib.rest_dur != 16'd0) begin
         if (!in_flush) begin
            if (flush_timer == 16'd0) begin
               in_flush    = 1'b1;
               flush_timer = calib.flush_dur;
            end
         end else if (flush_timer == 16'd0) begin
            in_flush    = 1'b0;
            flush_timer = calib.rest_dur;
         end
      end else begin
         in_flush    = 1'b0;
         flush_timer = '0;
      end

      if (!in_flush) begin
         if (demand < calib.min_press) demand = calib.min_press;
         if (demand > 16'(MaxPressure)) demand = 16'(MaxPressure);
      end

      // falling values go through the first-order filter
      if (demand < 16'(held_pressure)) begin
         wt     = (calib.smooth_w == 8'hFF) ? 8'hFE : calib.smooth_w;
         blend  = (22'(demand) + 22'(wt) * 22'(held_pressure)) / (22'(wt) + 22'd1);
         demand = blend[15:0];
      end

      held_pressure = demand[12:0];
      r.pressure    = demand[12:0];
      r.flushing    = in_flush;
   endtask

   // Drives one req word and books its expected rsp word at the accepting
   // edge. Valid is only lowered when a gap follows, so back-to-back words
   // keep it high without a second assignment in the same step.
   task automatic send_word(input demand_req_t w, input logic typed, input demand_t typed_want);
      int      gap;
      demand_t want;

      gap = calm_tx ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_gear_code       <= w.gear_code;
      req_input_torque    <= w.torque;
      req_oil_temperature <= w.oil_temp;
      req_flush_enable    <= w.flush_en;
      do @(posedge clock); while (req_stall);
      predict_demand(w, want);
      pending_demand.push_back(typed ? typed_want : want);
   endtask

   // sender holds off until every booked rsp word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_demand.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // New calibration, only once the block has gone idle.
   task automatic load_calib(input calib_t c);
      drain_results();
      repeat (4) @(posedge clock);
      write_reg(RegMultFirst, c.mult_first);
      write_reg(RegMultOther, c.mult_other);
      write_reg(RegRegSpring, c.reg_spring);
      write_reg(RegMinPress,  c.min_press);
      write_reg(RegSmoothW,   {8'd0, c.smooth_w});
      write_reg(RegFlushTemp, {8'd0, c.flush_temp});
      write_reg(RegRestDur,   c.rest_dur);
      write_reg(RegFlushDur,  c.flush_dur);
      csr_valid <= 1'b0;
      @(posedge clock);
      calib = c;
   endtask

   function automatic logic [7:0] drive_gear();
      logic [7:0] g;
      case ($urandom_range(0, 5))
         0: g = GearFirst;
         1: g = GearSecond;
         2: g = GearThird;
         3: g = GearFourth;
         4: g = GearFifth;
         default: g = GearRevFirst;
      endcase
      return g;
   endfunction

   // unconstrained word, weighted toward real gears and moderate torque
   function automatic demand_req_t any_word();
      demand_req_t w;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: w.gear_code = drive_gear();
         6: w.gear_code = GearPark;
         7: w.gear_code = GearNeutral;
         default: w.gear_code = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 2))
         0: w.torque = 16'($urandom_range(0, 65535));
         1: w.torque = 16'($urandom_range(0, 3000));
         default: w.torque = 16'($urandom_range(0, 400));
      endcase
      w.oil_temp = 8'($urandom_range(0, 255));
      w.flush_en = ($urandom_range(0, 3) != 0);
      return w;
   endfunction

   // Words that keep the flush machine cycling: zero demand, hot oil and
   // flush enabled, with a little noise that breaks the sequence.
   function automatic demand_req_t flush_word();
      demand_req_t w;
      if ($urandom_range(0, 19) == 0) begin
         w = any_word();
      end else begin
         w.torque = 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 4))
            0: w.gear_code = GearPark;
            1: w.gear_code = GearNeutral;
            2: w.gear_code = 8'($urandom_range(11, 255));
            default: begin
               w.gear_code = drive_gear();
               w.torque    = 16'($urandom_range(0, 60));   // stays under the spring
            end
         endcase
         w.oil_temp = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(205, 255));
         w.flush_en = ($urandom_range(0, 15) != 0);
      end
      return w;
   endfunction

   task automatic run_random(input int count, input int flush_pct);
      demand_req_t w;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) calm_tx = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 39) == 0) drain_results();
         if ($urandom_range(1, 100) <= flush_pct) w = flush_word();
         else w = any_word();
         send_word(w, 1'b0, '0);
      end
   endtask

   function automatic calib_t random_calib();
      calib_t c;
      c.mult_first = 16'($urandom_range(0, 2000));
      c.mult_other = 16'($urandom_range(0, 2000));
      c.reg_spring = 16'($urandom_range(0, 4000));
      c.min_press  = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8191));
      c.smooth_w   = 8'($urandom_range(0, 255));
      c.flush_temp = 8'($urandom_range(0, 255));
      c.rest_dur   = 16'($urandom_range(0, 12));
      c.flush_dur  = 16'($urandom_range(0, 10));
      return c;
   endfunction

   // rsp side: compare each accepted word, then draw the next stall stretch
   always @(posedge clock) begin : rsp_side
      int      n;
      demand_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_demand.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp word %0d unexpected: pressure %0d flushing %0b",
                           rsp_count, rsp_line_pressure, rsp_flushing);
            end else begin
               want = pending_demand.pop_front();
               if (rsp_line_pressure !== want.pressure || rsp_flushing !== want.flushing) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp word %0d: expected pressure %0d flushing %0b, got %0d %0b",
                              rsp_count, want.pressure, want.flushing,
                              rsp_line_pressure, rsp_flushing);
               end
            end
            rsp_count++;
            if (rsp_count % 25 == 0) calm_rx = ($urandom_range(0, 3) == 0);
            n          = calm_rx ? 0 : $urandom_range(0, 16);
            stall_left = n;
            rsp_stall <= (n != 0);
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   // hang detector: any accepted word on any channel resets the count
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
               $display("FAIL line_pressure_demand_with_flush");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      calib_t c;

      calib         = DefaultCalib;
      held_pressure = 13'(MaxPressure);
      in_flush      = 1'b0;
      flush_timer   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      run_random(60, 0);

      // everything at zero: flushing disabled, no floor, no smoothing
      load_calib('0);
      run_random(80, 20);

      // everything at maximum: floor above max pressure, weight 255 capped
      load_calib('1);
      run_random(80, 50);

      // Floor above max keeps the held pressure under the minimum, so the
      // flush machine cycles through short flush and rest periods.
      c            = DefaultCalib;
      c.min_press  = 16'hFFFF;
      c.smooth_w   = 8'($urandom_range(0, 6));
      c.rest_dur   = 16'($urandom_range(1, 6));
      c.flush_dur  = 16'($urandom_range(1, 8));
      load_calib(c);
      run_random(120, 90);

      // zero-length flushes with the heaviest filter
      c.flush_dur  = '0;
      c.rest_dur   = 16'($urandom_range(1, 3));
      c.smooth_w   = 8'hFF;
      c.flush_temp = 8'($urandom_range(0, 255));
      load_calib(c);
      run_random(60, 90);

      repeat (3) begin
         load_calib(random_calib());
         run_random(40, 50);
      end

      drain_results();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_demand.size() == 0) begin
         $display("PASS line_pressure_demand_with_flush");
      end else begin
         $display("FAIL line_pressure_demand_with_flush");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lpd_pkg.sv
hw/rtl/line_pressure_demand_with_flush.sv
tb/tb_top.sv
